>>> hw/rtl/gcis_pkg.sv
// Shared types and constants for the graph contract/identify/split block.
// Holds beat structs, op and status codes, and the row-transform control struct.
// No dependencies.
package gcis_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int ROW_W        = MAX_VERTICES;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = 6;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;

   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_EDGE = 3'd1;
   localparam logic [OP_W-1:0] OP_IDENTIFY = 3'd2;
   localparam logic [OP_W-1:0] OP_CONTRACT = 3'd3;
   localparam logic [OP_W-1:0] OP_SPLIT    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_ROW = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_VTX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_EDGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef enum logic [1:0] {
      KIND_SET_EDGE = 2'd0,
      KIND_SELF_CLR = 2'd1,
      KIND_SPLIT    = 2'd2,
      KIND_MERGE    = 2'd3
   } sweep_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] vertex_a;
      logic [CNT_W-1:0] vertex_b;
      logic             edge_value;
      logic [CNT_W-1:0] new_count;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    vertex_total;
      logic [ROW_W-1:0]    row_bits;
   } rsp_type;

   // Everything the row transform needs for one destination row of a sweep.
   typedef struct packed {
      sweep_kind_type   kind;
      logic [IDX_W-1:0] a_idx;
      logic [IDX_W-1:0] b_idx;
      logic             edge_value;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] dst;
      logic [CNT_W-1:0] src;
      logic [ROW_W-1:0] row_a;
      logic [ROW_W-1:0] merged;
   } xform_ctl_type;

endpackage

>>> hw/rtl/gcis_row_mem.sv
// Adjacency row store: one write port, one registered read port.
// Per-row valid bits give all-zero rows after reset or a clear op.
// Depends on gcis_pkg.
module gcis_row_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear_all,
   input  logic                        wr_en,
   input  logic [gcis_pkg::IDX_W-1:0]  wr_addr,
   input  logic [gcis_pkg::ROW_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [gcis_pkg::IDX_W-1:0]  rd_addr,
   output logic [gcis_pkg::ROW_W-1:0]  rd_row
);

   logic [gcis_pkg::ROW_W-1:0]        mem [gcis_pkg::MAX_VERTICES];
   logic [gcis_pkg::MAX_VERTICES-1:0] valid_ff;
   logic [gcis_pkg::ROW_W-1:0]        rd_data_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // a row never written since the last clear reads as empty
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hw/rtl/gcis_row_xform.sv
// Per-row update applied during a sweep: edge set, self-loop clear, split column
// append, and merge (fold column of B into A, then squeeze out row/column B).
// Depends on gcis_pkg.
module gcis_row_xform (
   input  gcis_pkg::xform_ctl_type     ctl,
   input  logic [gcis_pkg::ROW_W-1:0]  row_in,
   output logic [gcis_pkg::ROW_W-1:0]  row_out
);

   logic [gcis_pkg::ROW_W-1:0] y;
   logic [gcis_pkg::ROW_W-1:0] low_mask;
   logic [gcis_pkg::IDX_W-1:0] new_idx;
   logic [gcis_pkg::IDX_W-1:0] src_idx;

   always_comb begin
      y        = row_in;
      new_idx  = ctl.count[gcis_pkg::IDX_W-1:0];
      src_idx  = ctl.src[gcis_pkg::IDX_W-1:0];
      low_mask = (gcis_pkg::ROW_W'(1) << ctl.b_idx) - gcis_pkg::ROW_W'(1);
      case (ctl.kind)
         gcis_pkg::KIND_SET_EDGE: begin
            if (ctl.dst == ctl.a_idx) begin
               y[ctl.b_idx] = ctl.edge_value;
            end
            if (ctl.dst == ctl.b_idx) begin
               y[ctl.a_idx] = ctl.edge_value;
            end
         end
         gcis_pkg::KIND_SELF_CLR: begin
            if (ctl.dst == ctl.a_idx) begin
               y[ctl.a_idx] = 1'b0;
            end
         end
         gcis_pkg::KIND_SPLIT: begin
            // new vertex sits at index count; it copies A and links to A
            if (ctl.dst == new_idx) begin
               y = ctl.row_a | (gcis_pkg::ROW_W'(1) << ctl.a_idx);
            end else begin
               y[new_idx] = ctl.row_a[ctl.dst] | (ctl.dst == ctl.a_idx);
            end
         end
         gcis_pkg::KIND_MERGE: begin
            if (ctl.src >= ctl.count) begin
               y = '0;
            end else if (src_idx == ctl.a_idx) begin
               y = ctl.merged;
            end else begin
               y[ctl.a_idx] = ctl.merged[src_idx];
            end
            y = (y & low_mask) | ((y >> 1) & ~low_mask);
         end
         default: begin
            y = row_in;
         end
      endcase
      row_out = y;
   end

endmodule

>>> hw/rtl/graph_contract_identify_split.sv
// Graph edit engine: undirected graph as a bit adjacency matrix plus vertex count.
// Input channel req_*: one beat per operation (clear, set edge, identify,
// contract, split, read row). Output channel rsp_*: exactly one beat per request
// with status, vertex count and the row of vertex_a after the operation.
// One request is in flight at a time; req_stall is high from acceptance until the
// result is registered. A clear goes straight from acceptance to the result state;
// reads, errors and no-op merges first pass through states RD_A and RD_B, as rows
// A and B are fetched through the single memory read port. Any edit other than a
// clear that changes the matrix then also sweeps all 32 rows through the memory,
// one read and one write per cycle, before its result state.
// The result sits in an output register; a new request is accepted while it waits
// for rsp_stall to drop, and the next result waits behind it.
// Reset (synchronous) empties the matrix through per-row valid bits and sets the
// vertex count to zero; no clearing pass is needed.
// Depends on gcis_pkg, gcis_row_mem, gcis_row_xform.
module graph_contract_identify_split (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gcis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gcis_pkg::rsp_type rsp_data
);

   localparam int IDX_W = gcis_pkg::IDX_W;
   localparam int CNT_W = gcis_pkg::CNT_W;
   localparam int ROW_W = gcis_pkg::ROW_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(gcis_pkg::MAX_VERTICES);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RD_A  = 5'b00010,
      ST_RD_B  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   gcis_pkg::req_type         req_ff, req_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ROW_W-1:0]          row_a_ff, row_a_in;
   logic [ROW_W-1:0]          merged_ff, merged_in;
   gcis_pkg::sweep_kind_type  kind_ff, kind_in;
   logic [CNT_W-1:0]          step_ff, step_in;
   logic [CNT_W-1:0]          src_prev_ff, src_prev_in;
   logic [ROW_W-1:0]          res_row_ff, res_row_in;
   logic [1:0]                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   gcis_pkg::rsp_type         rsp_ff, rsp_in;

   logic                      mem_clear;
   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   logic [ROW_W-1:0]          mem_wr_data;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   logic [ROW_W-1:0]          rd_row;

   gcis_pkg::xform_ctl_type   xf_ctl;
   logic [ROW_W-1:0]          xf_out;

   logic                      req_fire;
   logic                      rsp_load;
   logic [CNT_W-1:0]          req_a_m1;
   logic [CNT_W-1:0]          a_m1;
   logic [CNT_W-1:0]          b_m1;
   logic [IDX_W-1:0]          a_idx;
   logic [IDX_W-1:0]          b_idx;
   logic                      va_ok;
   logic                      vb_ok;
   logic [CNT_W-1:0]          src_cur;
   logic [CNT_W-1:0]          dst_full;
   logic [IDX_W-1:0]          dst;
   logic [ROW_W-1:0]          merge_or;
   logic [ROW_W-1:0]          ab_bits;
   logic                      self_loop;

   gcis_row_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (mem_clear),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_row    (rd_row)
   );

   gcis_row_xform u_xform (
      .ctl     (xf_ctl),
      .row_in  (rd_row),
      .row_out (xf_out)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_a_m1 = req_data.vertex_a - CNT_W'(1);
   assign a_m1     = req_ff.vertex_a - CNT_W'(1);
   assign b_m1     = req_ff.vertex_b - CNT_W'(1);
   assign a_idx    = a_m1[IDX_W-1:0];
   assign b_idx    = b_m1[IDX_W-1:0];
   assign va_ok    = (req_ff.vertex_a != '0) && (req_ff.vertex_a <= count_ff);
   assign vb_ok    = (req_ff.vertex_b != '0) && (req_ff.vertex_b <= count_ff);

   // merge sweep reads one row ahead once past B, so B's row is dropped
   assign src_cur  = ((kind_ff == gcis_pkg::KIND_MERGE) && (step_ff >= CNT_W'(b_idx)))
                     ? step_ff + CNT_W'(1) : step_ff;
   assign dst_full = step_ff - CNT_W'(1);
   assign dst      = dst_full[IDX_W-1:0];

   assign merge_or  = row_a_ff | rd_row;
   assign ab_bits   = (ROW_W'(1) << a_idx) | (ROW_W'(1) << b_idx);
   // contract drops the A-B edge first, so only the two self-loops count there
   assign self_loop = (req_ff.op == gcis_pkg::OP_CONTRACT)
                      ? (row_a_ff[a_idx] | rd_row[b_idx])
                      : (merge_or[a_idx] | merge_or[b_idx]);

   always_comb begin
      xf_ctl.kind       = kind_ff;
      xf_ctl.a_idx      = a_idx;
      xf_ctl.b_idx      = b_idx;
      xf_ctl.edge_value = req_ff.edge_value;
      xf_ctl.count      = count_ff;
      xf_ctl.dst        = dst;
      xf_ctl.src        = src_prev_ff;
      xf_ctl.row_a      = row_a_ff;
      xf_ctl.merged     = merged_ff;
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      row_a_in     = row_a_ff;
      merged_in    = merged_ff;
      kind_in      = kind_ff;
      step_in      = step_ff;
      src_prev_in  = src_prev_ff;
      res_row_in   = res_row_ff;
      status_in    = status_ff;
      mem_clear    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = dst;
      mem_wr_data  = xf_out;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = a_idx;
      rsp_in.status       = status_ff;
      rsp_in.vertex_total = count_ff;
      rsp_in.row_bits     = va_ok ? res_row_ff : '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
               if (req_data.op == gcis_pkg::OP_CLEAR) begin
                  mem_clear  = 1'b1;
                  count_in   = (req_data.new_count > MAX_CNT) ? MAX_CNT : req_data.new_count;
                  status_in  = gcis_pkg::STATUS_OK;
                  res_row_in = '0;
                  state_in   = ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_a_m1[IDX_W-1:0];
                  state_in    = ST_RD_A;
               end
            end
         end
         ST_RD_A: begin
            row_a_in    = rd_row;
            mem_rd_en   = 1'b1;
            mem_rd_addr = b_idx;
            state_in    = ST_RD_B;
         end
         ST_RD_B: begin
            // rd_row holds row B here; decide status and whether to sweep
            status_in  = gcis_pkg::STATUS_OK;
            res_row_in = row_a_ff;
            merged_in  = (merge_or & ~ab_bits) | (self_loop ? (ROW_W'(1) << a_idx) : '0);
            step_in    = '0;
            state_in   = ST_DONE;
            case (req_ff.op)
               gcis_pkg::OP_SET_EDGE: begin
                  if (!va_ok || !vb_ok) begin
                     status_in = gcis_pkg::STATUS_BAD_VTX;
                  end else begin
                     kind_in  = gcis_pkg::KIND_SET_EDGE;
                     state_in = ST_SWEEP;
                  end
               end
               gcis_pkg::OP_IDENTIFY: begin
                  if (!va_ok || !vb_ok) begin
                     status_in = gcis_pkg::STATUS_BAD_VTX;
                  end else if (a_idx != b_idx) begin
                     kind_in  = gcis_pkg::KIND_MERGE;
                     state_in = ST_SWEEP;
                  end
               end
               gcis_pkg::OP_CONTRACT: begin
                  if (!va_ok || !vb_ok) begin
                     status_in = gcis_pkg::STATUS_BAD_VTX;
                  end else if (!row_a_ff[b_idx]) begin
                     status_in = gcis_pkg::STATUS_NO_EDGE;
                  end else if (a_idx == b_idx) begin
                     kind_in  = gcis_pkg::KIND_SELF_CLR;
                     state_in = ST_SWEEP;
                  end else begin
                     kind_in  = gcis_pkg::KIND_MERGE;
                     state_in = ST_SWEEP;
                  end
               end
               gcis_pkg::OP_SPLIT: begin
                  if (!va_ok) begin
                     status_in = gcis_pkg::STATUS_BAD_VTX;
                  end else if (count_ff >= MAX_CNT) begin
                     status_in = gcis_pkg::STATUS_FULL;
                  end else begin
                     kind_in  = gcis_pkg::KIND_SPLIT;
                     state_in = ST_SWEEP;
                  end
               end
               gcis_pkg::OP_READ_ROW: begin
                  if (!va_ok) begin
                     status_in = gcis_pkg::STATUS_BAD_VTX;
                  end
               end
               default: begin
                  status_in = gcis_pkg::STATUS_OK;
               end
            endcase
         end
         ST_SWEEP: begin
            // read source for row step, write back row step-1; writes trail reads
            step_in = step_ff + CNT_W'(1);
            if (step_ff < MAX_CNT) begin
               mem_rd_en   = (src_cur < MAX_CNT);
               mem_rd_addr = src_cur[IDX_W-1:0];
               src_prev_in = src_cur;
            end
            if (step_ff != '0) begin
               mem_wr_en = 1'b1;
               if (dst == a_idx) begin
                  res_row_in = xf_out;
               end
            end
            if (step_ff == MAX_CNT) begin
               state_in = ST_DONE;
               case (kind_ff)
                  gcis_pkg::KIND_MERGE: count_in = count_ff - CNT_W'(1);
                  gcis_pkg::KIND_SPLIT: count_in = count_ff + CNT_W'(1);
                  default:              count_in = count_ff;
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= gcis_pkg::KIND_SET_EDGE;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      row_a_ff    <= row_a_in;
      merged_ff   <= merged_in;
      src_prev_ff <= src_prev_in;
      res_row_ff  <= res_row_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("vertex count above capacity");

   a_sweep_order: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr < mem_rd_addr))
      else $error("sweep write caught up with its read");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && step_ff == MAX_CNT) |=> (state_ff == ST_DONE))
      else $error("sweep did not finish after last row");

   a_rsp_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not registered when output slot was free");

endmodule

>>> tb/tb.sv
// Self-checking bench for graph_contract_identify_split: drives edit ops on the
// req_ channel, predicts each result from its own copy of the adjacency matrix
// and checks every rsp_ beat in order. Depends on gcis_pkg and the block.
module tb;

   localparam logic [gcis_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd6;
   localparam logic [gcis_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;
   localparam int LATENCY_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   gcis_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   gcis_pkg::rsp_type rsp_data;

   // predicted graph
   logic [gcis_pkg::ROW_W-1:0] graph_rows [gcis_pkg::MAX_VERTICES];
   int                         graph_count;

   gcis_pkg::rsp_type owed_results [$];
   gcis_pkg::rsp_type want;
   int      failures = 0;
   bit      idle_on = 1'b1;
   bit      long_hold_pending = 1'b0;

   graph_contract_identify_split uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void link_pair(int a, int b, logic on);
      graph_rows[a][b] = on;
      graph_rows[b][a] = on;
   endfunction

   // Fold B into A, then delete B and renumber the later vertices down.
   function automatic void merge_pair(int a, int b);
      logic [gcis_pkg::ROW_W-1:0] merged;
      logic [gcis_pkg::ROW_W-1:0] row;
      logic                       self_loop;
      int                         k;
      merged = graph_rows[a] | graph_rows[b];
      self_loop = merged[a] | merged[b];
      merged[a] = 1'b0;
      merged[b] = 1'b0;
      if (self_loop)
         merged[a] = 1'b1;
      graph_rows[a] = merged;
      for (k = 0; k < graph_count; k++)
         if (k != a)
            link_pair(a, k, merged[k]);
      for (k = b; k + 1 < graph_count; k++)
         graph_rows[k] = graph_rows[k+1];
      graph_rows[graph_count-1] = '0;
      graph_count--;
      // squeeze column b out of every row
      for (k = 0; k < gcis_pkg::MAX_VERTICES; k++) begin
         row = graph_rows[k];
         graph_rows[k] = (row & ((32'd1 << b) - 32'd1)) | (((row >> b) >> 1) << b);
      end
   endfunction

   function automatic gcis_pkg::rsp_type apply_graph_op(gcis_pkg::req_type item);
      gcis_pkg::rsp_type          res;
      int                         a, b, c, k;
      logic [gcis_pkg::ROW_W-1:0] row;
      bit                         a_ok, b_ok;
      res = '0;
      a = int'(item.vertex_a) - 1;
      b = int'(item.vertex_b) - 1;
      a_ok = item.vertex_a >= 1 && item.vertex_a <= graph_count;
      b_ok = item.vertex_b >= 1 && item.vertex_b <= graph_count;
      res.status = gcis_pkg::STATUS_OK;
      case (item.op)
         gcis_pkg::OP_CLEAR: begin
            for (k = 0; k < gcis_pkg::MAX_VERTICES; k++)
               graph_rows[k] = '0;
            graph_count = (item.new_count > gcis_pkg::MAX_VERTICES) ? gcis_pkg::MAX_VERTICES
                                                                    : int'(item.new_count);
         end
         gcis_pkg::OP_SET_EDGE: begin
            if (!a_ok || !b_ok)
               res.status = gcis_pkg::STATUS_BAD_VTX;
            else
               link_pair(a, b, item.edge_value);
         end
         gcis_pkg::OP_IDENTIFY: begin
            if (!a_ok || !b_ok)
               res.status = gcis_pkg::STATUS_BAD_VTX;
            else if (a != b)
               merge_pair(a, b);
         end
         gcis_pkg::OP_CONTRACT: begin
            if (!a_ok || !b_ok)
               res.status = gcis_pkg::STATUS_BAD_VTX;
            else if (!graph_rows[a][b])
               res.status = gcis_pkg::STATUS_NO_EDGE;
            else if (a == b)
               graph_rows[a][a] = 1'b0;
            else begin
               link_pair(a, b, 1'b0);
               merge_pair(a, b);
            end
         end
         gcis_pkg::OP_SPLIT: begin
            if (!a_ok)
               res.status = gcis_pkg::STATUS_BAD_VTX;
            else if (graph_count >= gcis_pkg::MAX_VERTICES)
               res.status = gcis_pkg::STATUS_FULL;
            else begin
               c = graph_count;
               row = graph_rows[a];
               graph_count++;
               graph_rows[c] = '0;
               for (k = 0; k < c; k++)
                  if (row[k])
                     link_pair(c, k, 1'b1);
               link_pair(a, c, 1'b1);
            end
         end
         gcis_pkg::OP_READ_ROW: begin
            if (!a_ok)
               res.status = gcis_pkg::STATUS_BAD_VTX;
         end
         default: ;
      endcase
      res.vertex_total = gcis_pkg::CNT_W'(graph_count);
      // row is taken by number after the op, so a merge may renumber it
      if (item.vertex_a >= 1 && item.vertex_a <= graph_count)
         res.row_bits = graph_rows[a];
      return res;
   endfunction

   // prediction on every accepted request beat
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         owed_results.push_back(apply_graph_op(req_data));
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            $error("result beat with nothing expected: status %0d total %0d row %h",
                   rsp_data.status, rsp_data.vertex_total, rsp_data.row_bits);
            failures++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.vertex_total !== want.vertex_total) begin
               $error("vertex_total: expected %0d, got %0d",
                      want.vertex_total, rsp_data.vertex_total);
               failures++;
            end
            if (rsp_data.row_bits !== want.row_bits) begin
               $error("row_bits: expected %h, got %h", want.row_bits, rsp_data.row_bits);
               failures++;
            end
         end
      end
   end

   // result side: random stall bursts, plus one long hold on request
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_op(input gcis_pkg::req_type item);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end else
         @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   function automatic gcis_pkg::req_type make_op(logic [gcis_pkg::OP_W-1:0] op, int a, int b,
                                                 bit ev, int nc);
      gcis_pkg::req_type item;
      item.op         = op;
      item.vertex_a   = gcis_pkg::CNT_W'(a);
      item.vertex_b   = gcis_pkg::CNT_W'(b);
      item.edge_value = ev;
      item.new_count  = gcis_pkg::CNT_W'(nc);
      return item;
   endfunction

   // mostly live vertices, with some zero, one past the end and raw values
   function automatic logic [gcis_pkg::CNT_W-1:0] pick_vertex();
      int n;
      n = graph_count;
      case ($urandom_range(0, 19))
         0: return '0;
         1: return gcis_pkg::CNT_W'(n + 1);
         2: return gcis_pkg::CNT_W'($urandom_range(0, 63));
         default: return (n == 0) ? gcis_pkg::CNT_W'(1)
                                  : gcis_pkg::CNT_W'($urandom_range(1, n));
      endcase
   endfunction

   function automatic gcis_pkg::req_type random_item();
      gcis_pkg::req_type          item;
      int                         pick, k, a;
      logic [gcis_pkg::ROW_W-1:0] row;
      item.op         = gcis_pkg::OP_READ_ROW;
      item.vertex_a   = pick_vertex();
      item.vertex_b   = ($urandom_range(0, 9) == 0) ? item.vertex_a : pick_vertex();
      item.edge_value = ($urandom_range(0, 3) != 0);
      item.new_count  = gcis_pkg::CNT_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         item.op = gcis_pkg::OP_CLEAR;
         case ($urandom_range(0, 9))
            0:       item.new_count = '0;
            1:       item.new_count = gcis_pkg::CNT_W'($urandom_range(32, 63));
            2:       item.new_count = gcis_pkg::CNT_W'($urandom_range(24, 32));
            default: item.new_count = gcis_pkg::CNT_W'($urandom_range(1, 12));
         endcase
      end else if (pick < 20)
         item.op = gcis_pkg::OP_SET_EDGE;
      else if (pick < 34)
         item.op = gcis_pkg::OP_IDENTIFY;
      else if (pick < 56) begin
         item.op = gcis_pkg::OP_CONTRACT;
         // aim at an edge that is present most of the time
         a = int'(item.vertex_a);
         if (a >= 1 && a <= graph_count && graph_rows[a-1] != '0 &&
             $urandom_range(0, 3) != 0) begin
            row = graph_rows[a-1];
            k = $urandom_range(0, gcis_pkg::ROW_W - 1);
            while (!row[k])
               k = (k + 1) % gcis_pkg::ROW_W;
            item.vertex_b = gcis_pkg::CNT_W'(k + 1);
         end
      end else if (pick < 78)
         item.op = gcis_pkg::OP_SPLIT;
      else if (pick < 96)
         item.op = gcis_pkg::OP_READ_ROW;
      else
         item.op = $urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
      return item;
   endfunction

   task automatic test_directed();
      send_op(make_op(gcis_pkg::OP_CLEAR, 0, 0, 0, 0));
      send_op(make_op(gcis_pkg::OP_READ_ROW, 1, 1, 0, 0));
      send_op(make_op(gcis_pkg::OP_SPLIT, 1, 0, 0, 0));
      send_op(make_op(gcis_pkg::OP_CLEAR, 0, 0, 0, 63));       // saturates at the maximum
      send_op(make_op(gcis_pkg::OP_SPLIT, 32, 0, 0, 0));       // full
      send_op(make_op(gcis_pkg::OP_READ_ROW, 32, 0, 0, 0));
      send_op(make_op(gcis_pkg::OP_READ_ROW, 33, 0, 0, 0));
      send_op(make_op(gcis_pkg::OP_CLEAR, 0, 0, 0, 4));
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 1, 2, 1, 0));
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 2, 3, 1, 0));
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 3, 3, 1, 0));     // self-loop
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 1, 4, 0, 0));
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 1, 5, 1, 0));     // B out of range
      send_op(make_op(gcis_pkg::OP_CONTRACT, 1, 3, 0, 0));     // no edge
      send_op(make_op(gcis_pkg::OP_CONTRACT, 3, 3, 0, 0));     // drops the self-loop only
      send_op(make_op(gcis_pkg::OP_CONTRACT, 3, 3, 0, 0));
      send_op(make_op(gcis_pkg::OP_SET_EDGE, 3, 3, 1, 0));
      send_op(make_op(gcis_pkg::OP_IDENTIFY, 2, 2, 0, 0));     // same vertex: no change
      send_op(make_op(gcis_pkg::OP_IDENTIFY, 3, 2, 0, 0));     // B below A, row renumbered
      send_op(make_op(gcis_pkg::OP_SPLIT, 2, 0, 0, 0));        // self-loop turns into an edge
      send_op(make_op(gcis_pkg::OP_CONTRACT, 1, 2, 0, 0));
      send_op(make_op(OP_RESERVED_LO, 1, 1, 0, 0));
      send_op(make_op(OP_RESERVED_HI, 63, 63, 1, 63));
      send_op(make_op(gcis_pkg::OP_IDENTIFY, 1, 0, 0, 0));
      send_op(make_op(gcis_pkg::OP_CONTRACT, 0, 1, 0, 0));
      wait_drain();
   endtask

   // result side holds off while requests keep coming, so the block backs up
   task automatic test_long_hold();
      send_op(make_op(gcis_pkg::OP_CLEAR, 0, 0, 0, 8));
      long_hold_pending = 1'b1;
      repeat (10) send_op(random_item());
      wait_drain();
   endtask

   task automatic test_random_episodes();
      int blk;
      for (blk = 0; blk < 16; blk++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (50) send_op(random_item());
      end
      idle_on = 1'b1;
      wait_drain();
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      send_op(make_op(gcis_pkg::OP_CLEAR, 0, 0, 0, 30));
      repeat (99) send_op(random_item());
      wait_drain();
   endtask

   initial begin
      int k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      graph_count = 0;
      for (k = 0; k < gcis_pkg::MAX_VERTICES; k++)
         graph_rows[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_hold();
      test_random_episodes();
      test_quiet_tail();

      if (failures == 0)
         $display("graph_contract_identify_split: match");
      else
         $display("graph_contract_identify_split: mismatch");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("graph_contract_identify_split: mismatch");
      $finish;
   end

endmodule
